FILE: hdl/assert_macros.svh
// assertion macros for the soil saturation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, off while reset is low
`define SVG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check that also holds in reset
`define SVG_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define SVG_ASSERT(lbl, clk, rst_n, prop)
`define SVG_ASSERT_NR(lbl, clk, prop)

`endif

`endif

FILE: hdl/svg_pkg.sv
package svg_pkg;

    localparam int SOIL_COUNT = 10;
    localparam int STEPS      = 16;
    localparam int LOGA_W     = 44;
    localparam int LOGB_W     = 32;
    localparam int NEGA_W     = 26;
    localparam int NEGB_W     = 27;
    localparam int LOG2_LAT   = STEPS + 2;
    localparam int NEG2_LAT   = STEPS + 2;
    localparam int PIPE_LAT   = 2 * LOG2_LAT + 2 * NEG2_LAT + 9;
    localparam int ADDR_W     = 3;

    // register index, taken from paddr[2]
    localparam logic REG_WATER_TABLE = 1'b0;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef struct packed {
        logic signed [23:0] depth;
        logic [3:0]         soil_type;
    } t_req;

    typedef struct packed {
        logic signed [24:0] pressure_head;
        logic [16:0]        effective_saturation;
        logic [16:0]        total_saturation;
        logic               bad_soil_type;
    } t_res;

    typedef struct packed {
        logic [19:0] alpha;
        logic [17:0] n;
        logic [15:0] m;
        logic [14:0] swr;
    } t_soil;

    // data that travels beside the arithmetic
    typedef struct packed {
        logic signed [24:0] h;
        logic               pos;
        logic               bad;
        logic [17:0]        n;
        logic [15:0]        m;
        logic [14:0]        swr;
        logic [24:0]        tpos;
    } t_side;

    function automatic t_soil soil_rom(input logic [3:0] code);
        t_soil s;
        unique case (code)
            4'd0:    s = '{20'd52429,  18'd71434,  16'd5411,  15'd11727};
            4'd1:    s = '{20'd104858, 18'd89784,  16'd17699, 15'd4844};
            4'd2:    s = '{20'd124518, 18'd85852,  16'd15508, 15'd15185};
            4'd3:    s = '{20'd235930, 18'd102236, 16'd23526, 15'd11888};
            4'd4:    s = '{20'd812646, 18'd83886,  16'd14336, 15'd9111};
            4'd5:    s = '{20'd950272, 18'd175636, 16'd41082, 15'd6858};
            4'd6:    s = '{20'd950272, 18'd175636, 16'd41082, 15'd6858};
            4'd7:    s = '{20'd176947, 18'd80609,  16'd12255, 15'd17246};
            4'd8:    s = '{20'd65536,  18'd80609,  16'd12255, 15'd13564};
            4'd9:    s = '{20'd491520, 18'd123863, 16'd30861, 15'd10390};
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        x = v;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in q1.30, built by repeated square roots from 2.0
    function automatic logic [30:0] exp_tab(input int k);
        logic [63:0] t;
        t = 64'd1 << 31;
        for (int j = 1; j <= k; j++) begin
            t = isqrt64(t << 30);
        end
        return t[30:0];
    endfunction

endpackage

FILE: hdl/svg_log2.sv
module svg_log2 import svg_pkg::*; #(
    parameter int IN_W = LOGA_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [IN_W-1:0]            i_val,
    input  t_side                      i_side,
    output logic                       o_valid,
    output logic [$clog2(IN_W)+15:0]   o_log,
    output t_side                      o_side
);

    localparam int EW = $clog2(IN_W);

    // msb search
    logic [EW-1:0] n_e;
    always_comb begin
        n_e = '0;
        for (int j = 0; j < IN_W; j++) begin
            if (i_val[j]) n_e = EW'(j);
        end
    end

    logic            r_a_valid;
    logic [IN_W-1:0] r_a_v;
    logic [EW-1:0]   r_a_e;
    logic            r_a_zero;
    t_side           r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_valid <= 1'b0;
        else          r_a_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        r_a_v    <= i_val;
        r_a_e    <= n_e;
        r_a_zero <= (i_val == '0);
        r_a_side <= i_side;
    end

    // normalize to q1.30
    logic [IN_W-1:0] n_norm;
    assign n_norm = r_a_v << (EW'(IN_W - 1) - r_a_e);

    logic          r_valid [0:STEPS];
    logic [30:0]   r_mant  [0:STEPS];
    logic [15:0]   r_frac  [0:STEPS];
    logic [EW-1:0] r_e     [0:STEPS];
    logic          r_zero  [0:STEPS];
    t_side         r_side  [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid[0] <= 1'b0;
        else          r_valid[0] <= r_a_valid;
    end

    always_ff @(posedge i_clk) begin
        r_mant[0] <= n_norm[IN_W-1 -: 31];
        r_frac[0] <= '0;
        r_e[0]    <= r_a_e;
        r_zero[0] <= r_a_zero;
        r_side[0] <= r_a_side;
    end

    // one fraction bit per stage
    for (genvar k = 1; k <= STEPS; k++) begin : g_sq
        logic [61:0] n_sq;
        logic [30:0] n_mant;
        assign n_sq   = 62'(r_mant[k-1]) * 62'(r_mant[k-1]);
        assign n_mant = n_sq[61] ? n_sq[61:31] : n_sq[60:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_valid[k] <= 1'b0;
            else          r_valid[k] <= r_valid[k-1];
        end

        always_ff @(posedge i_clk) begin
            r_mant[k] <= n_mant;
            r_frac[k] <= {r_frac[k-1][14:0], n_sq[61]};
            r_e[k]    <= r_e[k-1];
            r_zero[k] <= r_zero[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_valid = r_valid[STEPS];
    assign o_log   = r_zero[STEPS] ? '0 : {r_e[STEPS], r_frac[STEPS]};
    assign o_side  = r_side[STEPS];

endmodule

FILE: hdl/svg_neg2.sv
module svg_neg2 import svg_pkg::*; #(
    parameter int A_W = NEGA_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [A_W-1:0] i_a,
    input  t_side          i_side,
    output logic           o_valid,
    output logic [30:0]    o_val,
    output t_side          o_side
);

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    logic [15:0] n_f;
    logic        n_big;
    assign n_f   = i_a[15:0];
    assign n_big = |i_a[A_W-1:21];

    logic        r_valid [0:STEPS];
    logic [30:0] r_acc   [0:STEPS];
    logic [15:0] r_x     [0:STEPS];
    logic [4:0]  r_sh    [0:STEPS];
    logic        r_big   [0:STEPS];
    logic        r_fz    [0:STEPS];
    t_side       r_side  [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid[0] <= 1'b0;
        else          r_valid[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        r_acc[0]  <= ONE_Q30;
        r_x[0]    <= 16'(~n_f + 16'd1);
        r_sh[0]   <= i_a[20:16];
        r_big[0]  <= n_big;
        r_fz[0]   <= (n_f == '0);
        r_side[0] <= i_side;
    end

    // one exponent bit per stage, msb first
    for (genvar k = 1; k <= STEPS; k++) begin : g_mul
        localparam logic [30:0] T_K = exp_tab(k);
        logic [61:0] n_prod;
        assign n_prod = 62'(r_acc[k-1]) * 62'(T_K);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_valid[k] <= 1'b0;
            else          r_valid[k] <= r_valid[k-1];
        end

        always_ff @(posedge i_clk) begin
            r_acc[k]  <= r_x[k-1][STEPS-k] ? n_prod[60:30] : r_acc[k-1];
            r_x[k]    <= r_x[k-1];
            r_sh[k]   <= r_sh[k-1];
            r_big[k]  <= r_big[k-1];
            r_fz[k]   <= r_fz[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    logic [30:0] n_val;
    always_comb begin
        priority if (r_big[STEPS]) begin
            n_val = '0;
        end else if (r_fz[STEPS]) begin
            n_val = ONE_Q30 >> r_sh[STEPS];
        end else begin
            n_val = r_acc[STEPS] >> ({1'b0, r_sh[STEPS]} + 6'd1);
        end
    end

    logic  r_o_valid;
    t_side r_o_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else          r_o_valid <= r_valid[STEPS];
    end

    always_ff @(posedge i_clk) begin
        o_val    <= n_val;
        r_o_side <= r_side[STEPS];
    end

    assign o_valid = r_o_valid;
    assign o_side  = r_o_side;

endmodule

FILE: hdl/soil_saturation_van_genuchten.sv
// van genuchten soil saturation, one profile point per request. a request is taken
// whenever start is high: busy is always low and a new point may enter every cycle.
// the result appears on o_res with o_strobe high for exactly one cycle; the receiver
// cannot stall it and it is never repeated. the path runs through four 18-register
// units (two log2 square-and-compare units and two 2^-x multiply units, each 16
// stages of one multiplier plus two registers for normalize or select) plus nine
// stages of add, multiply and select.
// water_table_depth lives at byte address 0 of the apb port.
`include "assert_macros.svh"

module soil_saturation_van_genuchten import svg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_strobe,
    output t_res              o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ---------------- configuration port ----------------
    logic signed [23:0] r_wtd;
    logic               n_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign n_wr   = psel && penable && pwrite && (paddr[2] == REG_WATER_TABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_wtd <= '0;
        else if (n_wr) r_wtd <= pwdata[23:0];
    end

    // reads sign-extend the register, unused address reads as zero
    assign prdata = (paddr[2] == REG_WATER_TABLE) ? {{8{r_wtd[23]}}, r_wtd} : '0;

    // ---------------- stage 1: head and soil lookup ----------------
    logic signed [24:0] n_h;
    assign n_h = {i_req.depth[23], i_req.depth} + {r_wtd[23], r_wtd};

    logic               r1_valid;
    logic signed [24:0] r1_h;
    logic               r1_pos;
    logic               r1_bad;
    t_soil              r1_soil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else          r1_valid <= start && !busy;
    end

    always_ff @(posedge i_clk) begin
        r1_h    <= n_h;
        r1_pos  <= !n_h[24] && (n_h != '0);
        r1_bad  <= (i_req.soil_type >= 4'(SOIL_COUNT));
        r1_soil <= soil_rom(i_req.soil_type);
    end

    // ---------------- stage 2: alpha * h ----------------
    logic              r2_valid;
    logic [LOGA_W-1:0] r2_prod;
    t_side             r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else          r2_valid <= r1_valid;
    end

    always_ff @(posedge i_clk) begin
        r2_prod      <= LOGA_W'(r1_soil.alpha) * LOGA_W'(r1_h[23:0]);
        r2_side.h    <= r1_h;
        r2_side.pos  <= r1_pos;
        r2_side.bad  <= r1_bad;
        r2_side.n    <= r1_soil.n;
        r2_side.m    <= r1_soil.m;
        r2_side.swr  <= r1_soil.swr;
        r2_side.tpos <= '0;
    end

    // ---------------- log2(alpha*h) ----------------
    logic        la_valid;
    logic [21:0] la_log;
    t_side       la_side;

    svg_log2 #(.IN_W(LOGA_W)) u_log_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_val   (r2_prod),
        .i_side  (r2_side),
        .o_valid (la_valid),
        .o_log   (la_log),
        .o_side  (la_side)
    );

    // ---------------- stage 3: n * log2(alpha h), q.16 ----------------
    logic signed [22:0] n3_l;
    assign n3_l = $signed({1'b0, la_log}) - 23'sd2097152;

    logic               r3_valid;
    logic signed [41:0] r3_prod;
    t_side              r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_valid <= 1'b0;
        else          r3_valid <= la_valid;
    end

    always_ff @(posedge i_clk) begin
        r3_prod <= $signed({{19{n3_l[22]}}, n3_l}) * $signed({24'd0, la_side.n});
        r3_side <= la_side;
    end

    // ---------------- stage 4: floor, magnitude and positive part ----------------
    logic signed [25:0] n4_t;
    assign n4_t = r3_prod[41:16];

    t_side n4_side;
    always_comb begin
        n4_side      = r3_side;
        n4_side.tpos = n4_t[25] ? '0 : n4_t[24:0];
    end

    logic              r4_valid;
    logic [NEGA_W-1:0] r4_at;
    t_side             r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_valid <= 1'b0;
        else          r4_valid <= r3_valid;
    end

    always_ff @(posedge i_clk) begin
        r4_at   <= n4_t[25] ? NEGA_W'(-n4_t) : NEGA_W'(n4_t);
        r4_side <= n4_side;
    end

    // ---------------- 2^-|t| ----------------
    logic        na_valid;
    logic [30:0] na_val;
    t_side       na_side;

    svg_neg2 #(.A_W(NEGA_W)) u_neg_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_valid),
        .i_a     (r4_at),
        .i_side  (r4_side),
        .o_valid (na_valid),
        .o_val   (na_val),
        .o_side  (na_side)
    );

    // ---------------- log2(1 + 2^-|t|), in q.30 ----------------
    logic [LOGB_W-1:0] n5_v;
    assign n5_v = LOGB_W'(na_val) + LOGB_W'(32'h4000_0000);

    logic        lb_valid;
    logic [20:0] lb_log;
    t_side       lb_side;

    svg_log2 #(.IN_W(LOGB_W)) u_log_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (na_valid),
        .i_val   (n5_v),
        .i_side  (na_side),
        .o_valid (lb_valid),
        .o_log   (lb_log),
        .o_side  (lb_side)
    );

    // ---------------- stage 6: log2(1 + (alpha h)^n) ----------------
    logic        r6_valid;
    logic [26:0] r6_s;
    t_side       r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_valid <= 1'b0;
        else          r6_valid <= lb_valid;
    end

    always_ff @(posedge i_clk) begin
        r6_s    <= 27'(lb_side.tpos) + 27'(lb_log) - 27'd1966080;
        r6_side <= lb_side;
    end

    // ---------------- stage 7: m * s ----------------
    logic        r7_valid;
    logic [42:0] r7_prod;
    t_side       r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_valid <= 1'b0;
        else          r7_valid <= r6_valid;
    end

    always_ff @(posedge i_clk) begin
        r7_prod <= 43'(r6_side.m) * 43'(r6_s);
        r7_side <= r6_side;
    end

    // ---------------- 2^-w ----------------
    logic        nb_valid;
    logic [30:0] nb_val;
    t_side       nb_side;

    svg_neg2 #(.A_W(NEGB_W)) u_neg_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_valid),
        .i_a     (r7_prod[42:16]),
        .i_side  (r7_side),
        .o_valid (nb_valid),
        .o_val   (nb_val),
        .o_side  (nb_side)
    );

    // ---------------- stage 9: round to q1.16, saturated and invalid cases ----------------
    logic [31:0] n9_round;
    assign n9_round = (32'(nb_val) + 32'd8192) >> 14;

    logic        r9_valid;
    logic [16:0] r9_swe;
    t_side       r9_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_valid <= 1'b0;
        else          r9_valid <= nb_valid;
    end

    always_ff @(posedge i_clk) begin
        priority if (nb_side.bad) begin
            r9_swe <= '0;
        end else if (!nb_side.pos) begin
            r9_swe <= ONE_Q16;
        end else begin
            r9_swe <= n9_round[16:0];
        end
        r9_side <= nb_side;
    end

    // ---------------- stage 10: swe * (1 - swr) ----------------
    logic        r10_valid;
    logic [33:0] r10_prod;
    logic [16:0] r10_swe;
    t_side       r10_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_valid <= 1'b0;
        else          r10_valid <= r9_valid;
    end

    always_ff @(posedge i_clk) begin
        r10_prod <= 34'(r9_swe) * 34'(ONE_Q16 - 17'(r9_side.swr));
        r10_swe  <= r9_swe;
        r10_side <= r9_side;
    end

    // ---------------- stage 11: output register ----------------
    logic [33:0] n11_sw;
    assign n11_sw = ((r10_prod + 34'd32768) >> 16) + 34'(r10_side.swr);

    logic r_strobe;
    t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else          r_strobe <= r10_valid;
    end

    always_ff @(posedge i_clk) begin
        r_res.pressure_head        <= r10_side.bad ? '0 : r10_side.h;
        r_res.effective_saturation <= r10_swe;
        r_res.total_saturation     <= r10_side.bad ? '0 : n11_sw[16:0];
        r_res.bad_soil_type        <= r10_side.bad;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // ---------------- checks ----------------
    logic res_zero;
    logic res_full;
    logic res_in_range;
    logic res_sat_zone;

    assign res_zero     = o_res.pressure_head == '0 && o_res.effective_saturation == '0
                          && o_res.total_saturation == '0;
    assign res_full     = o_res.effective_saturation == ONE_Q16
                          && o_res.total_saturation == ONE_Q16;
    assign res_in_range = o_res.effective_saturation <= ONE_Q16
                          && o_res.total_saturation <= ONE_Q16;
    assign res_sat_zone = !o_res.bad_soil_type && o_res.pressure_head <= 0;

    `SVG_ASSERT(a_latency, i_clk, i_rst_n, (start && !busy) |-> ##PIPE_LAT o_strobe)
    `SVG_ASSERT(a_no_stray, i_clk, i_rst_n, o_strobe |-> $past(start, PIPE_LAT))
    `SVG_ASSERT(a_bad_zero, i_clk, i_rst_n, (o_strobe && o_res.bad_soil_type) |-> res_zero)
    `SVG_ASSERT(a_saturated, i_clk, i_rst_n, (o_strobe && res_sat_zone) |-> res_full)
    `SVG_ASSERT(a_range, i_clk, i_rst_n, o_strobe |-> res_in_range)

endmodule

FILE: tb/sv/soil_saturation_van_genuchten_chk.sv
module soil_saturation_van_genuchten_chk import svg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  t_req        i_req,
    input  logic        o_strobe,
    input  t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    logic signed [23:0] water_table;
    t_res               sat_queue[$];
    logic [63:0]        root_tab[17];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    initial begin
        root_tab[0] = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) root_tab[k] = int_sqrt(root_tab[k-1] << 30);
    end

    function automatic longint log2_fix(input logic [63:0] v);
        int          e;
        logic [63:0] mant;
        logic [63:0] frac;
        e = 63;
        frac = 0;
        if (v == 0) return 0;
        while (v[e] == 1'b0) e--;
        mant = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        for (int i = 0; i < 16; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31)) begin
                mant = mant >> 1;
                frac = frac | 1;
            end
        end
        return longint'((64'(e) << 16) | frac);
    endfunction

    // 2^-a, a in q.16, result q.30
    function automatic logic [63:0] pow2_neg(input logic [63:0] a);
        logic [63:0] ip;
        logic [31:0] f;
        logic [31:0] x;
        logic [63:0] acc;
        ip = a >> 16;
        f = a[15:0];
        if (ip > 31) return 0;
        if (f == 0) return (64'd1 << 30) >> ip;
        x = 32'd65536 - f;
        acc = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
            if (x[16-k]) acc = (acc * root_tab[k]) >> 30;
        return acc >> (ip + 1);
    endfunction

    function automatic longint floor16(input longint x);
        if (x >= 0) return x >>> 16;
        return -((-x + 65535) >>> 16);
    endfunction

    function automatic t_res saturation_of(input t_req rq);
        t_res        r;
        t_soil       s;
        longint      h;
        longint      lg;
        longint      t;
        longint      sum;
        longint      w;
        logic [63:0] swe;
        logic [63:0] at;
        r = '0;
        if (rq.soil_type >= SOIL_COUNT) begin
            r.bad_soil_type = 1'b1;
            return r;
        end
        s = soil_rom(rq.soil_type);
        h = longint'(rq.depth) + longint'(water_table);
        if (h <= 0) begin
            swe = 65536;
        end else begin
            lg = log2_fix(64'(s.alpha) * 64'(h)) - (longint'(32) << 16);
            t = floor16(longint'(s.n) * lg);
            at = (t >= 0) ? t : -t;
            sum = (t > 0 ? t : 0) + log2_fix((64'd1 << 30) + pow2_neg(at))
                  - (longint'(30) << 16);
            w = floor16(longint'(s.m) * sum);
            if (w < 0) w = 0;
            swe = (pow2_neg(w) + (64'd1 << 13)) >> 14;
        end
        r.pressure_head = h[24:0];
        r.effective_saturation = swe[16:0];
        r.total_saturation = 17'(((swe * (65536 - s.swr) + 32768) >> 16) + s.swr);
        return r;
    endfunction

    assign o_pending = sat_queue.size();

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            water_table <= '0;
            o_fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_WATER_TABLE)
                water_table <= pwdata[23:0];
            if (start && !busy) sat_queue.push_back(saturation_of(i_req));
            if (o_strobe) begin
                if (sat_queue.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %p", o_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = sat_queue.pop_front();
                    if (want !== o_res) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p got %p", want, o_res);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/sv/soil_saturation_van_genuchten_tb.sv
module soil_saturation_van_genuchten_tb;
    import svg_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_strobe;
    t_res o_res;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_count;
    int pending;
    int idle_cycles = 0;

    localparam int WATCHDOG_LIMIT = 20 * PIPE_LAT + 1000;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    soil_saturation_van_genuchten uut (.*);

    soil_saturation_van_genuchten_chk checker_inst (
        .i_clk, .i_rst_n, .start, .busy, .i_req, .o_strobe, .o_res,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: cycles with neither a request taken nor a result delivered
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("soil_saturation_van_genuchten regression: fail");
            $finish;
        end
    end

    // apb write: setup cycle then access cycle
    task automatic write_water_table(input logic signed [23:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // send one request, holding start until taken; idle_pct sets sender gaps
    task automatic send_point(input logic signed [23:0] depth, input logic [3:0] soil,
                              input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= '{depth: depth, soil_type: soil};
        do @(posedge i_clk); while (busy);
    endtask

    // drain the pipeline before touching the register
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    // mostly a small band around the water table so the curve is exercised
    function automatic logic signed [23:0] rand_depth(input logic signed [23:0] wt);
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 6) return 24'(-int'(wt) + $signed($urandom_range(1 << 20)) - (1 << 15));
        if (sel < 8) return 24'(-int'(wt) + $signed($urandom_range(1 << 17)));
        return 24'($urandom);
    endfunction

    initial begin
        logic signed [23:0] wt_set[5];
        int idle_set[4];
        wt_set = '{24'sd0, 24'sh7FFFFF, -24'sh800000, 24'sd131072, -24'sd65536};
        idle_set = '{0, 60, 60, 38};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, each soil, saturated and invalid codes
        for (int s = 0; s < 16; s++) send_point(24'(s * 40000), 4'(s), 0);
        send_point(24'sh7FFFFF, 4'd0, 0);
        send_point(-24'sh800000, 4'd9, 0);
        send_point(24'sd0, 4'd5, 0);
        send_point(24'sd1, 4'd5, 0);
        send_point(24'sh7FFFFF, 4'd5, 0);
        send_point(-24'sd1, 4'd15, 0);
        drain();

        // random phases across several water table settings
        for (int ph = 0; ph < 5; ph++) begin
            write_water_table(wt_set[ph]);
            repeat (2) @(posedge i_clk);
            for (int i = 0; i < 205; i++)
                send_point(rand_depth(wt_set[ph]),
                           ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10))
                                                    : 4'($urandom_range(9)),
                           idle_set[(ph + i / 50) % 4]);
            drain();
        end

        if (fail_count == 0) begin
            $display("soil_saturation_van_genuchten regression: pass");
        end else begin
            $display("soil_saturation_van_genuchten regression: fail");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+hdl
hdl/svg_pkg.sv
hdl/svg_log2.sv
hdl/svg_neg2.sv
hdl/soil_saturation_van_genuchten.sv
tb/sv/soil_saturation_van_genuchten_chk.sv
tb/sv/soil_saturation_van_genuchten_tb.sv
